// ----- hdl/cts_pkg.sv -----
package cts_pkg;

   // counter width for output positions
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   // longest held tag prefix: "<c-" plus six hex digits
   localparam int HELD_MAX = 9;

   // result kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_SET    = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   // match phases
   localparam logic [3:0] PH_IDLE     = 4'd0;   // nothing pending
   localparam logic [3:0] PH_LT       = 4'd1;   // "<"
   localparam logic [3:0] PH_LT_SLASH = 4'd2;   // "</"
   localparam logic [3:0] PH_CANCEL_C = 4'd3;   // "</c"
   localparam logic [3:0] PH_LT_C     = 4'd4;   // "<c"
   localparam logic [3:0] PH_HEX0     = 4'd5;   // "<c-"
   localparam logic [3:0] PH_HEX5     = 4'd10;  // "<c-" and five digits
   localparam logic [3:0] PH_HEX_FULL = 4'd11;  // "<c-" and six digits

   // characters of the tags
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_CHAR,
      TAIL_SET,
      TAIL_CANCEL
   } tail_type;

   typedef logic [HELD_MAX-1:0][7:0] held_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_char;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] position;
      logic        last_of_run;
      logic        string_done;
   } rsp_type;

   // one input word's worth of results: held bytes, then an optional tail
   typedef struct packed {
      held_type            held;
      logic [3:0]          held_cnt;
      tail_type            tail;
      logic [7:0]          tail_char;
      logic [23:0]         rgb;
      logic [POS_BITS-1:0] pos;
      logic                eos;
   } run_type;

   function automatic logic [7:0] hex_ascii(input logic [3:0] v, input logic up);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = CH_0 + {4'b0000, v};
      end else begin
         r = (up ? CH_UA : CH_LA) + {4'b0000, v} - 8'd10;
      end
      return r;
   endfunction

   // number of bytes held back in a phase
   function automatic logic [3:0] held_count(input logic [3:0] phase);
      logic [3:0] n;
      case (phase)
         PH_LT:       n = 4'd1;
         PH_LT_SLASH: n = 4'd2;
         PH_CANCEL_C: n = 4'd3;
         PH_LT_C:     n = 4'd2;
         default: begin
            if (phase inside {[PH_HEX0:PH_HEX_FULL]}) begin
               n = phase - 4'd2;
            end else begin
               n = 4'd0;
            end
         end
      endcase
      return n;
   endfunction

   // held bytes of a phase in text order; bytes past the count are don't care
   function automatic held_type held_bytes(input logic [3:0] phase,
                                           input logic [23:0] hex,
                                           input logic [5:0] hcase);
      held_type    h;
      logic [3:0]  k;
      logic [2:0]  gap;
      logic [23:0] al;
      logic [5:0]  cal;
      logic        cancel;
      h = '0;
      k = (phase inside {[PH_HEX0:PH_HEX_FULL]}) ? (phase - PH_HEX0) : 4'd0;
      gap = 3'(4'd6 - k);
      al = hex << {gap, 2'b00};
      cal = hcase << gap;
      cancel = (phase == PH_LT_SLASH) || (phase == PH_CANCEL_C);
      h[0] = CH_LT;
      h[1] = cancel ? CH_SLASH : CH_C;
      h[2] = cancel ? CH_C : CH_DASH;
      for (int j = 0; j < 6; j++) begin
         h[3+j] = hex_ascii(al[23-4*j -: 4], cal[5-j]);
      end
      return h;
   endfunction

endpackage

// ----- hdl/cts_match.sv -----
module cts_match (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  cts_pkg::req_type req_word,
   output cts_pkg::run_type run,
   output logic             run_live
);

   logic [3:0]                   phase_ff, phase_in;
   logic [23:0]                  hex_ff, hex_in;
   logic [5:0]                   case_ff, case_in;
   logic [cts_pkg::POS_BITS-1:0] count_ff, count_in;

   logic [7:0]  c;
   logic        eos;
   logic        hex_ok, hex_up;
   logic [3:0]  hex_val;
   logic        fail, plain, ext;
   cts_pkg::tail_type tail;
   logic [3:0]  step_phase, snap_phase;
   logic [23:0] step_hex, snap_hex;
   logic [5:0]  step_case, snap_case;
   logic [3:0]  held_len, nchars;
   logic [cts_pkg::POS_BITS:0] sum;

   always_comb begin
      c = req_word.in_char;
      eos = req_word.end_of_string;

      // hex digit decode
      hex_ok = 1'b1;
      hex_up = 1'b0;
      hex_val = 4'd0;
      if (c inside {[cts_pkg::CH_0:cts_pkg::CH_9]}) begin
         hex_val = 4'(c - cts_pkg::CH_0);
      end else if (c inside {[cts_pkg::CH_LA:cts_pkg::CH_LF]}) begin
         hex_val = 4'(c - cts_pkg::CH_LA + 8'd10);
      end else if (c inside {[cts_pkg::CH_UA:cts_pkg::CH_UF]}) begin
         hex_val = 4'(c - cts_pkg::CH_UA + 8'd10);
         hex_up = 1'b1;
      end else begin
         hex_ok = 1'b0;
      end

      fail = 1'b0;
      plain = 1'b0;
      tail = cts_pkg::TAIL_NONE;
      step_phase = phase_ff;
      step_hex = hex_ff;
      step_case = case_ff;

      case (phase_ff)
         cts_pkg::PH_LT: begin
            if (c == cts_pkg::CH_SLASH) begin
               step_phase = cts_pkg::PH_LT_SLASH;
            end else if (c == cts_pkg::CH_C) begin
               step_phase = cts_pkg::PH_LT_C;
            end else begin
               fail = 1'b1;
            end
         end
         cts_pkg::PH_LT_SLASH: begin
            if (c == cts_pkg::CH_C) begin
               step_phase = cts_pkg::PH_CANCEL_C;
            end else begin
               fail = 1'b1;
            end
         end
         cts_pkg::PH_CANCEL_C: begin
            if (c == cts_pkg::CH_GT) begin
               tail = cts_pkg::TAIL_CANCEL;
            end else begin
               fail = 1'b1;
            end
         end
         cts_pkg::PH_LT_C: begin
            if (c == cts_pkg::CH_DASH) begin
               step_phase = cts_pkg::PH_HEX0;
            end else begin
               fail = 1'b1;
            end
         end
         cts_pkg::PH_HEX_FULL: begin
            if (c == cts_pkg::CH_GT) begin
               tail = cts_pkg::TAIL_SET;
            end else begin
               fail = 1'b1;
            end
         end
         default: begin
            if (phase_ff inside {[cts_pkg::PH_HEX0:cts_pkg::PH_HEX5]}) begin
               if (hex_ok) begin
                  step_phase = phase_ff + 4'd1;
                  step_hex = {hex_ff[19:0], hex_val};
                  step_case = {case_ff[4:0], hex_up};
               end else begin
                  fail = 1'b1;
               end
            end else begin
               plain = 1'b1;
            end
         end
      endcase

      ext = !fail && !plain && (tail == cts_pkg::TAIL_NONE);

      if (fail || plain) begin
         // a '<' opens a new match unless the string ends; anything else is a character
         step_phase = (c == cts_pkg::CH_LT) ? cts_pkg::PH_LT : cts_pkg::PH_IDLE;
         step_hex = '0;
         step_case = '0;
         if ((c != cts_pkg::CH_LT) || eos) begin
            tail = cts_pkg::TAIL_CHAR;
         end
      end else if (!ext) begin
         step_phase = cts_pkg::PH_IDLE;
         step_hex = '0;
         step_case = '0;
      end

      // which prefix gets flushed as characters
      if (fail) begin
         snap_phase = phase_ff;
         snap_hex = hex_ff;
         snap_case = case_ff;
      end else if (ext && eos) begin
         snap_phase = step_phase;
         snap_hex = step_hex;
         snap_case = step_case;
      end else begin
         snap_phase = cts_pkg::PH_IDLE;
         snap_hex = '0;
         snap_case = '0;
      end

      held_len = cts_pkg::held_count(snap_phase);
      nchars = held_len + {3'b000, tail == cts_pkg::TAIL_CHAR};
      sum = {1'b0, count_ff} + (cts_pkg::POS_BITS+1)'(nchars);

      if (eos) begin
         phase_in = cts_pkg::PH_IDLE;
         hex_in = '0;
         case_in = '0;
         count_in = '0;
      end else begin
         phase_in = step_phase;
         hex_in = step_hex;
         case_in = step_case;
         count_in = (sum > {1'b0, cts_pkg::POS_MAX}) ? cts_pkg::POS_MAX
                                                      : sum[cts_pkg::POS_BITS-1:0];
      end

      run.held = cts_pkg::held_bytes(snap_phase, snap_hex, snap_case);
      run.held_cnt = held_len;
      run.tail = tail;
      run.tail_char = c;
      run.rgb = hex_ff;
      run.pos = count_ff;
      run.eos = eos;
      run_live = (held_len != 4'd0) || (tail != cts_pkg::TAIL_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cts_pkg::PH_IDLE;
         hex_ff <= '0;
         case_ff <= '0;
         count_ff <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         hex_ff <= hex_in;
         case_ff <= case_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/color_tag_stripper_core.sv -----
// channel   ports                            word              direction
// request   req_valid req_ready req_word     cts_pkg::req_type in: one text byte
// response  rsp_valid rsp_ready rsp_word     cts_pkg::rsp_type out: char or marker
//
// a byte that yields one result is taken every cycle while rsp_ready is high
// a byte that yields n results holds req_ready low while the run register
// hands out one word per cycle unless stalled (at most ten, a flushed tag prefix)
// a byte that only extends a partial tag yields nothing
// reset clears the match state, the position counter and both valid flags
// a stall on rsp_ready backs up through the run register to req_ready
module color_tag_stripper_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cts_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cts_pkg::rsp_type rsp_word
);

   // front end: tag matcher and run descriptor
   cts_pkg::run_type run_new;
   logic             run_live;
   logic             req_accept;

   // run register: results of one byte still to be sent
   cts_pkg::run_type run_ff, run_in;
   logic             run_valid_ff, run_valid_in;

   // output register
   cts_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic emit;
   logic run_last;

   assign req_accept = req_valid && req_ready;

   cts_match u_match (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_word   (req_word),
      .run        (run_new),
      .run_live   (run_live)
   );

   // a word moves when the output register is empty or being drained
   assign emit = run_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign run_last = (run_ff.held_cnt == 4'd0) ||
                     ((run_ff.held_cnt == 4'd1) && (run_ff.tail == cts_pkg::TAIL_NONE));
   // take a new byte when the run register is free by the end of this cycle
   assign req_ready = !run_valid_ff || (emit && run_last);

   always_comb begin
      // response word built from the head of the run
      rsp_in = '0;
      rsp_in.position = 16'(run_ff.pos);
      if (run_ff.held_cnt != 4'd0) begin
         rsp_in.kind = cts_pkg::KIND_CHAR;
         rsp_in.out_char = run_ff.held[0];
      end else begin
         case (run_ff.tail)
            cts_pkg::TAIL_CHAR: begin
               rsp_in.kind = cts_pkg::KIND_CHAR;
               rsp_in.out_char = run_ff.tail_char;
            end
            cts_pkg::TAIL_SET: begin
               rsp_in.kind = cts_pkg::KIND_SET;
               rsp_in.red = run_ff.rgb[23:16];
               rsp_in.green = run_ff.rgb[15:8];
               rsp_in.blue = run_ff.rgb[7:0];
            end
            cts_pkg::TAIL_CANCEL: begin
               rsp_in.kind = cts_pkg::KIND_CANCEL;
            end
            default: begin
               rsp_in.kind = cts_pkg::KIND_CHAR;
            end
         endcase
      end
      rsp_in.last_of_run = run_last;
      rsp_in.string_done = run_last && run_ff.eos;

      // advance the run: load a new one or shift held bytes and bump the position
      run_in = run_ff;
      run_valid_in = run_valid_ff;
      if (req_accept) begin
         run_in = run_new;
         run_valid_in = run_live;
      end else if (emit) begin
         if (run_last) begin
            run_valid_in = 1'b0;
         end else begin
            for (int i = 0; i < cts_pkg::HELD_MAX - 1; i++) begin
               run_in.held[i] = run_ff.held[i+1];
            end
            run_in.held_cnt = run_ff.held_cnt - 4'd1;
            run_in.pos = (run_ff.pos == cts_pkg::POS_MAX) ? cts_pkg::POS_MAX
                                                          : run_ff.pos + 1'b1;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   // a loaded run always has something to send
   a_run_not_empty: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> ((run_ff.held_cnt != 4'd0) || (run_ff.tail != cts_pkg::TAIL_NONE)))
      else $error("run register holds an empty run");

   // a word that is not the last of its run keeps the run alive
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (emit && !run_last) |=> run_valid_ff)
      else $error("run dropped before its last word");

   // markers carry no character byte
   a_marker_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind != cts_pkg::KIND_CHAR)) |-> (rsp_ff.out_char == 8'd0))
      else $error("marker word carries a character");

   // end of string only on the last word of a run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.string_done) |-> rsp_ff.last_of_run)
      else $error("string done on a word that is not last");

   // held count never exceeds the prefix buffer
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> (run_ff.held_cnt <= 4'(cts_pkg::HELD_MAX)))
      else $error("held count out of range");

endmodule
